@@ hw/rtl/rpp_pkg.sv @@
package rpp_pkg;

    // Field widths of the stream words.
    localparam int COORD_W = 32;
    localparam int ANGLE_W = 17;

    // Internal widths.
    localparam int A_W      = ANGLE_W + 1;   // angle during range reduction
    localparam int MAG_W    = 14;            // |angle| after folding, at most a quarter turn
    localparam int DIFF_W   = COORD_W + 1;   // exact point - pivot
    localparam int GUARD    = 4;             // extra fraction bits in the rotator
    localparam int CORD_W   = 42;            // rotator x/y width, covers gain growth
    localparam int ZW       = 33;            // residual angle, radians Q2.30
    localparam int SCALE_W  = 34;
    localparam int ANGP_W   = MAG_W + SCALE_W;
    localparam int GAIN_W   = 24;
    localparam int TABLE_LEN = 32;

    // Angle units: 128 steps per degree.
    localparam int DEG_HALF_CIRCLE = 180;
    localparam logic signed [A_W-1:0] FULL_TURN    = A_W'(46080);
    localparam logic signed [A_W-1:0] HALF_TURN    = A_W'(DEG_HALF_CIRCLE * 128);
    localparam logic signed [A_W-1:0] QUARTER_TURN = A_W'(11520);

    // pi/23040 in UQ0.46 and the CORDIC gain 0.60725293500888 in Q0.24.
    localparam logic [SCALE_W-1:0] ANG_SCALE = 34'd9595049034;
    localparam logic [GAIN_W-1:0]  GAIN_Q24  = 24'd10188014;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } coord_t;

    // Input word layout, last field in the lowest bits.
    typedef struct packed {
        logic signed [ANGLE_W-1:0] turn_angle;
        logic signed [COORD_W-1:0] pivot_y;
        logic signed [COORD_W-1:0] pivot_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_x;
    } in_item_t;

    localparam int IN_ITEM_W = $bits(in_item_t);
    localparam int IN_DATA_W = ((IN_ITEM_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = 2 * COORD_W;

    // One rotator stage's worth of state.
    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic signed [ZW-1:0]     z;
        coord_t                   pivot;
    } cordic_t;

    // atan(2^-i) in radians Q2.30, truncated.
    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            0:  v = 33'sd843314856;
            1:  v = 33'sd497837829;
            2:  v = 33'sd263043836;
            3:  v = 33'sd133525158;
            4:  v = 33'sd67021686;
            5:  v = 33'sd33543515;
            6:  v = 33'sd16775850;
            7:  v = 33'sd8388437;
            8:  v = 33'sd4194282;
            9:  v = 33'sd2097149;
            10: v = 33'sd1048575;
            11: v = 33'sd524287;
            12: v = 33'sd262143;
            13: v = 33'sd131071;
            14: v = 33'sd65535;
            15: v = 33'sd32767;
            16: v = 33'sd16383;
            17: v = 33'sd8191;
            18: v = 33'sd4095;
            19: v = 33'sd2047;
            20: v = 33'sd1023;
            21: v = 33'sd511;
            22: v = 33'sd255;
            23: v = 33'sd127;
            24: v = 33'sd63;
            25: v = 33'sd31;
            26: v = 33'sd15;
            27: v = 33'sd7;
            28: v = 33'sd3;
            29: v = 33'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/rpp_front.sv @@
module rpp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  rpp_pkg::in_item_t item,
    output logic              out_valid,
    output rpp_pkg::cordic_t  out_data
);
    import rpp_pkg::*;

    // Stage 1: offset and angle folding.
    logic                     v1_reg;
    logic signed [DIFF_W-1:0] dx1_reg, dx1_next, dy1_reg, dy1_next;
    logic                     flip1_reg, flip1_next;
    logic                     neg1_reg, neg1_next;
    logic [MAG_W-1:0]         mag1_reg, mag1_next;
    coord_t                   piv1_reg;

    // Stage 2: offset negation and angle scaling product.
    logic                     v2_reg;
    logic signed [DIFF_W-1:0] dx2_reg, dx2_next, dy2_reg, dy2_next;
    logic                     neg2_reg;
    logic [ANGP_W-1:0]        prod2_reg, prod2_next;
    coord_t                   piv2_reg;

    // Stage 3: rounded angle and guard-extended offset.
    logic                     v3_reg;
    cordic_t                  st3_reg, st3_next;

    logic signed [A_W-1:0]    a0, a1, a2, a3, am;
    logic [ANGP_W-1:0]        prod_rnd;
    logic signed [ZW-1:0]     zmag;

    always_comb
    begin
        a0 = A_W'(item.turn_angle);
        // Bring the angle within one turn (truncating remainder).
        if (a0 >= FULL_TURN)
        begin
            a1 = a0 - FULL_TURN;
        end
        else if (a0 <= -FULL_TURN)
        begin
            a1 = a0 + FULL_TURN;
        end
        else
        begin
            a1 = a0;
        end
        // Then within a half turn either way.
        if (a1 > HALF_TURN)
        begin
            a2 = a1 - FULL_TURN;
        end
        else if (a1 < -HALF_TURN)
        begin
            a2 = a1 + FULL_TURN;
        end
        else
        begin
            a2 = a1;
        end
        // Beyond a right angle, turn by a half circle and negate the offset.
        flip1_next = 1'b0;
        if (a2 > QUARTER_TURN)
        begin
            a3 = a2 - HALF_TURN;
            flip1_next = 1'b1;
        end
        else if (a2 < -QUARTER_TURN)
        begin
            a3 = a2 + HALF_TURN;
            flip1_next = 1'b1;
        end
        else
        begin
            a3 = a2;
        end
        neg1_next = a3[A_W-1];
        am        = neg1_next ? -a3 : a3;
        mag1_next = am[MAG_W-1:0];
        dx1_next  = DIFF_W'(item.point_x) - DIFF_W'(item.pivot_x);
        dy1_next  = DIFF_W'(item.point_y) - DIFF_W'(item.pivot_y);
    end

    always_comb
    begin
        dx2_next   = flip1_reg ? -dx1_reg : dx1_reg;
        dy2_next   = flip1_reg ? -dy1_reg : dy1_reg;
        prod2_next = ANGP_W'(mag1_reg) * ANGP_W'(ANG_SCALE);
    end

    always_comb
    begin
        prod_rnd       = prod2_reg + (ANGP_W'(1) << 15);
        zmag           = ZW'(prod_rnd[ANGP_W-1:16]);
        st3_next.z     = neg2_reg ? -zmag : zmag;
        st3_next.x     = {{(CORD_W-DIFF_W-GUARD){dx2_reg[DIFF_W-1]}}, dx2_reg, {GUARD{1'b0}}};
        st3_next.y     = {{(CORD_W-DIFF_W-GUARD){dy2_reg[DIFF_W-1]}}, dy2_reg, {GUARD{1'b0}}};
        st3_next.pivot = piv2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dx1_reg   <= dx1_next;
            dy1_reg   <= dy1_next;
            flip1_reg <= flip1_next;
            neg1_reg  <= neg1_next;
            mag1_reg  <= mag1_next;
            piv1_reg  <= '{x: item.pivot_x, y: item.pivot_y};
            dx2_reg   <= dx2_next;
            dy2_reg   <= dy2_next;
            neg2_reg  <= neg1_reg;
            prod2_reg <= prod2_next;
            piv2_reg  <= piv1_reg;
            st3_reg   <= st3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = st3_reg;

endmodule

@@ hw/rtl/rpp_cordic_stage.sv @@
module rpp_cordic_stage #(
    parameter int STAGE = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  rpp_pkg::cordic_t in_data,
    output logic             out_valid,
    output rpp_pkg::cordic_t out_data
);
    import rpp_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = atan_q30(STAGE);

    logic                     valid_reg;
    cordic_t                  data_reg, data_next;
    logic signed [CORD_W-1:0] xin, yin, xs, ys;

    always_comb
    begin
        xin = in_data.x;
        yin = in_data.y;
        xs  = xin >>> STAGE;
        ys  = yin >>> STAGE;
        data_next.pivot = in_data.pivot;
        // Drive the residual angle toward zero.
        if (!in_data.z[ZW-1])
        begin
            data_next.x = xin - ys;
            data_next.y = yin + xs;
            data_next.z = in_data.z - ATAN;
        end
        else
        begin
            data_next.x = xin + ys;
            data_next.y = yin - xs;
            data_next.z = in_data.z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hw/rtl/rpp_gain.sv @@
module rpp_gain (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_valid,
    input  rpp_pkg::cordic_t in_data,
    output logic             out_valid,
    output rpp_pkg::coord_t  rotated,
    output logic             saturated
);
    import rpp_pkg::*;

    // The wide gain product is split into two partial products at LO_W.
    localparam int LO_W    = CORD_W / 2;
    localparam int HI_W    = CORD_W - LO_W;
    localparam int PL_W    = LO_W + GAIN_W;
    localparam int PH_W    = HI_W + GAIN_W + 1;
    localparam int SW      = PH_W + LO_W + 1;
    localparam int FRAC_SH = GAIN_W + GUARD;
    localparam int RES_W   = SW - FRAC_SH;
    localparam int SUM_W   = RES_W + 1;
    localparam logic [SW-1:0] ROUND = SW'(1) << (FRAC_SH - 1);

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic [PL_W-1:0]         plx1_reg, ply1_reg;
    logic signed [PH_W-1:0]  phx1_reg, phy1_reg;
    coord_t                  piv1_reg, piv2_reg;
    logic signed [RES_W-1:0] rx2_reg, ry2_reg, rx2_next, ry2_next;
    logic signed [SUM_W-1:0] tx3_reg, ty3_reg;
    coord_t                  out_reg, out_next;
    logic                    sat_reg, sat_next;

    logic [SW-1:0]           sum_x, sum_y;
    logic                    ovf_x, ovf_y;

    always_comb
    begin
        sum_x    = (SW'(phx1_reg) << LO_W) + SW'(plx1_reg) + ROUND;
        sum_y    = (SW'(phy1_reg) << LO_W) + SW'(ply1_reg) + ROUND;
        rx2_next = $signed(sum_x[SW-1:FRAC_SH]);
        ry2_next = $signed(sum_y[SW-1:FRAC_SH]);
    end

    // Out of range when the sign bit of a 32-bit value and the bits above it disagree.
    always_comb
    begin
        ovf_x = !((&tx3_reg[SUM_W-1:COORD_W-1]) || !(|tx3_reg[SUM_W-1:COORD_W-1]));
        ovf_y = !((&ty3_reg[SUM_W-1:COORD_W-1]) || !(|ty3_reg[SUM_W-1:COORD_W-1]));
        out_next.x = ovf_x ? (tx3_reg[SUM_W-1] ? COORD_MIN : COORD_MAX)
                           : tx3_reg[COORD_W-1:0];
        out_next.y = ovf_y ? (ty3_reg[SUM_W-1] ? COORD_MIN : COORD_MAX)
                           : ty3_reg[COORD_W-1:0];
        sat_next   = ovf_x || ovf_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            plx1_reg <= PL_W'(in_data.x[LO_W-1:0]) * PL_W'(GAIN_Q24);
            ply1_reg <= PL_W'(in_data.y[LO_W-1:0]) * PL_W'(GAIN_Q24);
            phx1_reg <= PH_W'($signed(in_data.x[CORD_W-1:LO_W]))
                        * PH_W'($signed({1'b0, GAIN_Q24}));
            phy1_reg <= PH_W'($signed(in_data.y[CORD_W-1:LO_W]))
                        * PH_W'($signed({1'b0, GAIN_Q24}));
            piv1_reg <= in_data.pivot;
            rx2_reg  <= rx2_next;
            ry2_reg  <= ry2_next;
            piv2_reg <= piv1_reg;
            tx3_reg  <= SUM_W'(rx2_reg) + SUM_W'(piv2_reg.x);
            ty3_reg  <= SUM_W'(ry2_reg) + SUM_W'(piv2_reg.y);
            out_reg  <= out_next;
            sat_reg  <= sat_next;
        end
    end

    assign out_valid = v4_reg;
    assign rotated   = out_reg;
    assign saturated = sat_reg;

endmodule

@@ hw/rtl/rotate_point_about_pivot.sv @@
// Pipeline: an accepted input word reaches its result word through the stages
// (3 front stages, one stage per CORDIC iteration, 4 gain and clamp stages).
// Throughput: one word per cycle while the output is taken; each stage is a register.
// A back-pressured output stalls the whole pipeline.
// Reset: rst_n is asynchronous and active low; it clears all valid bits and the
// input skid buffer, so no result is presented after reset.
module rotate_point_about_pivot #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0 up: point_x, point_y, pivot_x, pivot_y, turn_angle, zero fill.
    input  logic [rpp_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // Fields from bit 0 up: rotated_x, rotated_y.
    output logic [rpp_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // Fields from bit 0 up: saturated.
    output logic                             m_axis_tuser
);
    import rpp_pkg::*;

    // The whole pipeline moves together; it only holds while the output word
    // is offered and not taken.
    logic adv;

    // A one-word skid buffer on the input keeps s_axis_tready a plain register,
    // so the input side never sees the output handshake combinationally. It
    // fills only when a word arrives in a cycle the pipeline is held.
    logic     skid_valid_reg, skid_valid_next;
    in_item_t skid_reg;
    in_item_t in_item;
    in_item_t head_item;
    logic     head_valid;

    cordic_t  stage_data  [CORDIC_STAGES+1];
    logic     stage_valid [CORDIC_STAGES+1];

    coord_t   rotated;
    logic     sat;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = !skid_valid_reg;
    assign in_item       = in_item_t'(s_axis_tdata[IN_ITEM_W-1:0]);
    assign head_valid    = skid_valid_reg || s_axis_tvalid;
    assign head_item     = skid_valid_reg ? skid_reg : in_item;

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (adv)
        begin
            skid_valid_next = 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!adv && s_axis_tvalid && s_axis_tready)
        begin
            skid_reg <= in_item;
        end
    end

    // Offset, angle reduction to a quarter turn and scaling to radians.
    rpp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (head_valid),
        .item      (head_item),
        .out_valid (stage_valid[0]),
        .out_data  (stage_data[0])
    );

    // One registered micro-rotation per stage.
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cordic
        rpp_cordic_stage #(
            .STAGE (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (stage_valid[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    // Gain compensation, pivot add-back and saturation; its last register is
    // the output register.
    rpp_gain u_gain (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (stage_valid[CORDIC_STAGES]),
        .in_data   (stage_data[CORDIC_STAGES]),
        .out_valid (m_axis_tvalid),
        .rotated   (rotated),
        .saturated (sat)
    );

    assign m_axis_tdata = {rotated.y, rotated.x};
    assign m_axis_tuser = sat;

endmodule

@@ hw/rtl/rpp_checker.sv @@
module rpp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // An offered output word stays offered until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word withdrawn before it was taken");

    // A stalled output word keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output word changed");

    // Input ready drops only when a word was taken while the output was held.
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |->
            $past(s_axis_tvalid && m_axis_tvalid && !m_axis_tready))
        else $error("input ready dropped without a held word");

    // Once the output side moves, the skid buffer drains and input is ready.
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_axis_tvalid || m_axis_tready) |=> s_axis_tready)
        else $error("input not ready after the output side moved");

    // A saturated word carries a clamped coordinate.
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[31:0] == 32'h7fff_ffff) || (m_axis_tdata[31:0] == 32'h8000_0000)
            || (m_axis_tdata[63:32] == 32'h7fff_ffff)
            || (m_axis_tdata[63:32] == 32'h8000_0000))
        else $error("saturated flag set on an unclamped word");

endmodule

bind rotate_point_about_pivot rpp_checker u_rpp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

@@ bench/tb_rotate_point_about_pivot.sv @@
`timescale 1ns / 1ps

module tb_rotate_point_about_pivot;

    import rpp_pkg::*;

    localparam int STAGES = 24;
    // Pipeline depth in stages (front, CORDIC and gain stages), used for the final drain.
    localparam int PIPE_DEPTH = STAGES + 7;
    localparam int RANDOM_WORDS = 550;

    // Angle constants in 1/128 degree steps and the scaling constants, widened for the predictor.
    localparam longint ONE_TURN = longint'(FULL_TURN);
    localparam longint HALF_OF_TURN = longint'(HALF_TURN);
    localparam longint RIGHT_ANGLE = longint'(QUARTER_TURN);
    localparam longint RAD_PER_STEP_Q16 = longint'(ANG_SCALE);
    localparam longint INV_GAIN_Q24 = longint'(GAIN_Q24);

    // One rotated point as it leaves the block.
    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      clamped;
    } rotated_t;

    // One row of the directed table. Rows with a typed-in answer carry it in want.
    typedef struct {
        in_item_t word;
        bit       typed;
        rotated_t want;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    // Points still on their way through the pipeline, oldest first.
    rotated_t      points_in_flight[$];
    directed_row_t directed_rows[$];

    // Arctangent of 2^-i in radians Q2.30, truncated.
    longint atan_rad_q30 [0:31] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
        15, 7, 3, 1, 0, 0
    };

    int  mismatches;
    int  words_sent;
    int  points_checked;
    int  clamped_seen;
    // While set, neither side of the stream idles.
    bit  no_idle;

    rotate_point_about_pivot #(
        .CORDIC_STAGES(STAGES)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // Hard stop in case the pipeline hangs or a result never shows up.
    initial
    begin
        #1_000_000;
        $display("tb_rotate_point_about_pivot NOT OK");
        $finish;
    end

    // Works out the rotated point for one input word. The offset from the pivot is
    // taken with guard bits, the angle is folded into plus or minus a right angle
    // (negating the offset when folded by half a turn), the CORDIC stages turn the
    // offset, and the gain-corrected result is added back to the pivot and clamped.
    function automatic rotated_t rotate_about_pivot(input in_item_t word);
        longint   piv_x;
        longint   piv_y;
        longint   off_x;
        longint   off_y;
        longint   steps;
        longint   mag;
        longint   resid;
        longint   shx;
        longint   shy;
        longint   sum_x;
        longint   sum_y;
        int       stage_count;
        rotated_t r;
        piv_x = longint'(word.pivot_x);
        piv_y = longint'(word.pivot_y);
        off_x = (longint'(word.point_x) - piv_x) * (64'sd1 <<< GUARD);
        off_y = (longint'(word.point_y) - piv_y) * (64'sd1 <<< GUARD);
        steps = longint'(word.turn_angle);

        // Wrap to one turn, then to within a half turn on either side, ends included.
        steps = steps % ONE_TURN;
        if (steps > HALF_OF_TURN)
            steps -= ONE_TURN;
        if (steps < -HALF_OF_TURN)
            steps += ONE_TURN;
        if (steps > RIGHT_ANGLE)
        begin
            steps -= HALF_OF_TURN;
            off_x = -off_x;
            off_y = -off_y;
        end
        else if (steps < -RIGHT_ANGLE)
        begin
            steps += HALF_OF_TURN;
            off_x = -off_x;
            off_y = -off_y;
        end

        // Radians in Q2.30, rounded half up on the magnitude.
        mag = (steps < 0) ? -steps : steps;
        resid = (mag * RAD_PER_STEP_Q16 + 32768) / 65536;
        if (steps < 0)
            resid = -resid;

        stage_count = (STAGES > 32) ? 32 : STAGES;
        for (int i = 0; i < stage_count; i++)
        begin
            shx = off_x >>> i;
            shy = off_y >>> i;
            if (resid >= 0)
            begin
                off_x -= shy;
                off_y += shx;
                resid -= atan_rad_q30[i];
            end
            else
            begin
                off_x += shy;
                off_y -= shx;
                resid += atan_rad_q30[i];
            end
        end

        sum_x = ((off_x * INV_GAIN_Q24 + (64'sd1 <<< (23 + GUARD))) >>> (24 + GUARD)) + piv_x;
        sum_y = ((off_y * INV_GAIN_Q24 + (64'sd1 <<< (23 + GUARD))) >>> (24 + GUARD)) + piv_y;

        r.clamped = 1'b0;
        if (sum_x > longint'(COORD_MAX))
        begin
            sum_x = longint'(COORD_MAX);
            r.clamped = 1'b1;
        end
        else if (sum_x < longint'(COORD_MIN))
        begin
            sum_x = longint'(COORD_MIN);
            r.clamped = 1'b1;
        end
        if (sum_y > longint'(COORD_MAX))
        begin
            sum_y = longint'(COORD_MAX);
            r.clamped = 1'b1;
        end
        else if (sum_y < longint'(COORD_MIN))
        begin
            sum_y = longint'(COORD_MIN);
            r.clamped = 1'b1;
        end
        r.x = sum_x[COORD_W-1:0];
        r.y = sum_y[COORD_W-1:0];
        return r;
    endfunction

    function automatic in_item_t make_word(input logic signed [COORD_W-1:0] px,
                                           input logic signed [COORD_W-1:0] py,
                                           input logic signed [COORD_W-1:0] vx,
                                           input logic signed [COORD_W-1:0] vy,
                                           input logic signed [ANGLE_W-1:0] ang);
        in_item_t w;
        w.point_x = px;
        w.point_y = py;
        w.pivot_x = vx;
        w.pivot_y = vy;
        w.turn_angle = ang;
        return w;
    endfunction

    // Adds a row to the directed table; typed rows carry a hand-derived answer.
    task automatic add_row(input in_item_t w, input bit typed,
                           input logic signed [COORD_W-1:0] ex,
                           input logic signed [COORD_W-1:0] ey,
                           input logic es);
        directed_row_t row;
        row.word = w;
        row.typed = typed;
        row.want.x = ex;
        row.want.y = ey;
        row.want.clamped = es;
        directed_rows.push_back(row);
    endtask

    // Offers one word on the input side. Called right after a rising edge; returns
    // right after the rising edge at which the word was taken. Readiness is looked
    // at on the falling edge, where nothing is changing.
    task automatic send_word(input in_item_t w, input bit typed, input rotated_t want);
        while (!no_idle && $urandom_range(99) < 15)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_W'(w);
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        points_in_flight.push_back(typed ? want : rotate_about_pivot(w));
        words_sent++;
        @(posedge clk);
    endtask

    // Random word. Most words are small offsets around a pivot, which keeps the
    // rotation well inside range; the rest use full-width coordinates or pivots
    // near the rails so that clamping in either direction comes up often.
    function automatic in_item_t random_word();
        logic signed [COORD_W-1:0] vx;
        logic signed [COORD_W-1:0] vy;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [ANGLE_W-1:0] ang;
        int                        pick;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            vx = int'($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
            vy = int'($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
            px = vx + (int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
            py = vy + (int'($urandom_range(32'h0020_0000)) - 32'sh0010_0000);
        end
        else if (pick < 85)
        begin
            vx = $urandom;
            vy = $urandom;
            px = $urandom;
            py = $urandom;
        end
        else
        begin
            vx = $urandom_range(1) ? COORD_MAX - $urandom_range(32'h00ff_ffff)
                                   : COORD_MIN + $urandom_range(32'h00ff_ffff);
            vy = $urandom_range(1) ? COORD_MAX - $urandom_range(32'h00ff_ffff)
                                   : COORD_MIN + $urandom_range(32'h00ff_ffff);
            px = vx + (int'($urandom_range(32'h1000_0000)) - 32'sh0800_0000);
            py = vy + (int'($urandom_range(32'h1000_0000)) - 32'sh0800_0000);
        end
        // Mostly angles within one turn either way; now and then any 17-bit pattern.
        if ($urandom_range(9) == 0)
            ang = ANGLE_W'($urandom);
        else
            ang = ANGLE_W'(int'($urandom_range(92160)) - 46080);
        return make_word(px, py, vx, vy, ang);
    endfunction

    // Output side readiness: random stalls, except during the calm stretch.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= no_idle || ($urandom_range(99) >= 15);
    end

    // Each word leaving the block is compared with the oldest point in flight.
    // Sampling on the falling edge sees the values the next rising edge will take.
    always @(negedge clk)
    begin
        rotated_t want;
        coord_t   got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = coord_t'(m_axis_tdata);
            if (points_in_flight.size() == 0)
            begin
                $display("%0t: unexpected word x=%h y=%h clamped=%b",
                         $time, got.x, got.y, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = points_in_flight.pop_front();
                points_checked++;
                if (m_axis_tuser)
                    clamped_seen++;
                if (got.x !== want.x)
                begin
                    $display("%0t: rotated_x expected %h actual %h", $time, want.x, got.x);
                    mismatches++;
                end
                if (got.y !== want.y)
                begin
                    $display("%0t: rotated_y expected %h actual %h", $time, want.y, got.y);
                    mismatches++;
                end
                if (m_axis_tuser !== want.clamped)
                begin
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.clamped, m_axis_tuser);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rotated_t none;
        in_item_t w;
        int       n_directed;
        none.x = '0;
        none.y = '0;
        none.clamped = 1'b0;
        mismatches = 0;
        words_sent = 0;
        points_checked = 0;
        clamped_seen = 0;
        no_idle = 1'b0;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;

        // A point sitting on its pivot stays there whatever the angle, so these rows
        // can be answered by hand, including pivots on the rails and full turns.
        add_row(make_word(0, 0, 0, 0, 0), 1'b1, 0, 0, 1'b0);
        add_row(make_word(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, 17'sd46080),
                1'b1, COORD_MAX, COORD_MIN, 1'b0);
        add_row(make_word(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, -17'sd46080),
                1'b1, COORD_MIN, COORD_MAX, 1'b0);
        add_row(make_word(32'sh0001_2345, -32'sh0004_0000, 32'sh0001_2345,
                          -32'sh0004_0000, 17'sd11521), 1'b1, 32'sh0001_2345,
                -32'sh0004_0000, 1'b0);
        // Unit point about the origin at right angles, half turns and their folds.
        add_row(make_word(32'sh0001_0000, 0, 0, 0, 17'sd11520), 1'b0, 0, 0, 1'b0);
        add_row(make_word(32'sh0001_0000, 0, 0, 0, -17'sd11520), 1'b0, 0, 0, 1'b0);
        add_row(make_word(32'sh0001_0000, 0, 0, 0, 17'sd11521), 1'b0, 0, 0, 1'b0);
        add_row(make_word(32'sh0001_0000, 0, 0, 0, -17'sd11521), 1'b0, 0, 0, 1'b0);
        add_row(make_word(0, 32'sh0001_0000, 0, 0, 17'sd23040), 1'b0, 0, 0, 1'b0);
        add_row(make_word(0, 32'sh0001_0000, 0, 0, -17'sd23040), 1'b0, 0, 0, 1'b0);
        add_row(make_word(32'sh0003_8000, -32'sh0002_4000, 0, 0, 17'sd46079),
                1'b0, 0, 0, 1'b0);
        add_row(make_word(32'sh0003_8000, -32'sh0002_4000, 0, 0, -17'sd46079),
                1'b0, 0, 0, 1'b0);
        // Patterns past a full turn still wrap.
        add_row(make_word(32'sh0010_0000, 32'sh0020_0000, 0, 0, 17'sh0ffff),
                1'b0, 0, 0, 1'b0);
        add_row(make_word(32'sh0010_0000, 32'sh0020_0000, 0, 0, 17'sh10000),
                1'b0, 0, 0, 1'b0);
        // Smallest angle steps and a plain rotation about an offset pivot.
        add_row(make_word(32'sh0100_0000, 0, 0, 0, 17'sd1), 1'b0, 0, 0, 1'b0);
        add_row(make_word(32'sh0100_0000, 0, 0, 0, -17'sd1), 1'b0, 0, 0, 1'b0);
        add_row(make_word(32'sh0003_8000, -32'sh0002_4000, 32'sh0001_0000, 32'sh0001_0000,
                          17'sd3840), 1'b0, 0, 0, 1'b0);
        // Widest offsets: no wrap in the middle, clamping at both rails.
        add_row(make_word(COORD_MAX, 0, COORD_MIN, 0, 0), 1'b0, 0, 0, 1'b0);
        add_row(make_word(COORD_MAX, 0, COORD_MIN, 0, 17'sd23040), 1'b0, 0, 0, 1'b0);
        add_row(make_word(COORD_MIN, 0, COORD_MAX, 0, 17'sd23040), 1'b0, 0, 0, 1'b0);
        add_row(make_word(COORD_MAX, COORD_MAX, 0, 0, 17'sd5760), 1'b0, 0, 0, 1'b0);
        add_row(make_word(COORD_MIN, COORD_MIN, 0, 0, 17'sd23040), 1'b0, 0, 0, 1'b0);
        add_row(make_word(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, -17'sd11520),
                1'b0, 0, 0, 1'b0);
        n_directed = directed_rows.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);

        // Random words, with a long stretch in the middle where both sides stream
        // back to back.
        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            no_idle = (i >= 200) && (i < 330);
            w = random_word();
            send_word(w, 1'b0, none);
        end
        no_idle = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (points_in_flight.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 8) @(posedge clk);

        $display("Sent %0d words (%0d from the directed table), checked %0d points,",
                 words_sent, n_directed, points_checked);
        $display("%0d of them clamped at a coordinate rail.", clamped_seen);
        if (mismatches == 0)
            $display("tb_rotate_point_about_pivot OK");
        else
            $display("tb_rotate_point_about_pivot NOT OK");
        $finish;
    end

endmodule
